>>> hw/rtl/csched_pkg.sv
// Shared types and constants for the C-LOOK request scheduler.
package csched_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int SECTOR_BITS_DEF = 48;
  localparam int TAG_BITS_DEF    = 8;

  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 3;

  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADD_SWEEP = 3'd0,
    ST_ADD_NEXT  = 3'd1,
    ST_REJECT    = 3'd2,
    ST_DISPATCH  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_POP,
    S_MV_LD,
    S_HEAD_RD,
    S_POS,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic sweep_we;
    logic next_we;
  } mem_ctl_t;

endpackage

>>> hw/rtl/csched_mem.sv
// Sweep and next-sweep list storage, one write and one registered read port each.
module csched_mem import csched_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ENTRY_W     = SECTOR_BITS_DEF + TAG_BITS_DEF
) (
  input  logic                           clk,
  input  mem_ctl_t                       mem_ctl,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] sweep_waddr,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] sweep_raddr,
  input  logic [ENTRY_W-1:0]             sweep_wdata,
  output logic [ENTRY_W-1:0]             sweep_rdata,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] next_waddr,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] next_raddr,
  input  logic [ENTRY_W-1:0]             next_wdata,
  output logic [ENTRY_W-1:0]             next_rdata
);

  logic [ENTRY_W-1:0] sweep_mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] next_mem  [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.sweep_we) begin
      sweep_mem[sweep_waddr] <= sweep_wdata;
    end
    sweep_rdata <= sweep_mem[sweep_raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rdata <= next_mem[next_raddr];
  end

endmodule

>>> hw/rtl/csched_seq.sv
// Scheduler sequencer: list pointers, shared sector comparator and control FSM.
module csched_seq import csched_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int SECTOR_BITS = SECTOR_BITS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  op_t                              start_op,
  input  logic [SECTOR_BITS-1:0]           start_sector,
  input  logic [TAG_BITS-1:0]              start_tag,
  output logic                             idle,
  output logic                             done,
  input  logic                             done_take,
  output status_t                          res_status,
  output logic [SECTOR_BITS-1:0]           res_sector,
  output logic [TAG_BITS-1:0]              res_tag,
  output logic [SECTOR_BITS-1:0]           res_head,
  output logic [COUNT_W-1:0]               res_sweep_count,
  output logic [COUNT_W-1:0]               res_next_count,
  output mem_ctl_t                         mem_ctl,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   sweep_waddr,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   sweep_raddr,
  output logic [SECTOR_BITS+TAG_BITS-1:0]  sweep_wdata,
  input  logic [SECTOR_BITS+TAG_BITS-1:0]  sweep_rdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   next_waddr,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   next_raddr,
  output logic [SECTOR_BITS+TAG_BITS-1:0]  next_wdata,
  input  logic [SECTOR_BITS+TAG_BITS-1:0]  next_rdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int EW = SECTOR_BITS + TAG_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // circular index: head plus logical offset, wrapped once
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] l);
    logic [SW-1:0] sum;
    sum = SW'(hd) + SW'(l);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  seq_state_t             state_r, state_nxt;
  logic [CW-1:0]          sweep_fill_r, sweep_fill_nxt;
  logic [CW-1:0]          next_fill_r, next_fill_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [SECTOR_BITS-1:0] pos_r, pos_nxt;
  logic [CW-1:0]          j_r, j_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic                   mv_r, mv_nxt;
  logic [SECTOR_BITS-1:0] sec_r, sec_nxt;
  logic [TAG_BITS-1:0]    tag_r, tag_nxt;
  status_t                status_r, status_nxt;
  logic [SECTOR_BITS-1:0] osec_r, osec_nxt;
  logic [TAG_BITS-1:0]    otag_r, otag_nxt;

  // shared comparator
  logic [SECTOR_BITS-1:0] cmp_a, cmp_b;
  logic                   a_lt_b, a_eq_b;

  logic                   ins_end;
  logic [CW-1:0]          j_stop;
  logic [CW-1:0]          i_inc;
  logic [CW-1:0]          fill_dec;
  logic [XW-1:0]          sweep_ext, next_ext;

  assign cmp_a  = (state_r == S_IDLE) ? start_sector : sweep_rdata[SECTOR_BITS-1:0];
  assign cmp_b  = (state_r == S_IDLE) ? pos_r : sec_r;
  assign a_lt_b = cmp_a < cmp_b;
  assign a_eq_b = cmp_a == cmp_b;

  assign j_stop   = mv_r ? '0 : ONE_C;
  assign i_inc    = i_r + ONE_C;
  assign fill_dec = sweep_fill_r - ONE_C;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sweep_fill_r <= '0;
      next_fill_r  <= '0;
      head_r       <= '0;
      pos_r        <= '1;
      mv_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_fill_r <= sweep_fill_nxt;
      next_fill_r  <= next_fill_nxt;
      head_r       <= head_nxt;
      pos_r        <= pos_nxt;
      mv_r         <= mv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    i_r      <= i_nxt;
    sec_r    <= sec_nxt;
    tag_r    <= tag_nxt;
    status_r <= status_nxt;
    osec_r   <= osec_nxt;
    otag_r   <= otag_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    sweep_fill_nxt = sweep_fill_r;
    next_fill_nxt  = next_fill_r;
    head_nxt       = head_r;
    pos_nxt        = pos_r;
    j_nxt          = j_r;
    i_nxt          = i_r;
    mv_nxt         = mv_r;
    sec_nxt        = sec_r;
    tag_nxt        = tag_r;
    status_nxt     = status_r;
    osec_nxt       = osec_r;
    otag_nxt       = otag_r;
    mem_ctl        = '0;
    sweep_waddr    = '0;
    sweep_raddr    = '0;
    sweep_wdata    = '0;
    next_waddr     = '0;
    next_raddr     = '0;
    next_wdata     = '0;
    idle           = 1'b0;
    done           = 1'b0;
    ins_end        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          sec_nxt  = start_sector;
          tag_nxt  = start_tag;
          osec_nxt = '0;
          otag_nxt = '0;
          mv_nxt   = 1'b0;
          if (start_op == OP_ADD) begin
            if (sweep_fill_r == '0 || !a_lt_b) begin
              if (sweep_fill_r == DEPTH_C) begin
                status_nxt = ST_REJECT;
                state_nxt  = S_DONE;
              end else if (sweep_fill_r == '0) begin
                mem_ctl.sweep_we = 1'b1;
                sweep_waddr      = head_r;
                sweep_wdata      = {start_tag, start_sector};
                sweep_fill_nxt   = ONE_C;
                pos_nxt          = start_sector;
                status_nxt       = ST_ADD_SWEEP;
                state_nxt        = S_DONE;
              end else begin
                j_nxt      = sweep_fill_r;
                status_nxt = ST_ADD_SWEEP;
                state_nxt  = S_INS_RD;
              end
            end else if (next_fill_r == DEPTH_C) begin
              status_nxt = ST_REJECT;
              state_nxt  = S_DONE;
            end else begin
              mem_ctl.next_we = 1'b1;
              next_waddr      = next_fill_r[AW-1:0];
              next_wdata      = {start_tag, start_sector};
              next_fill_nxt   = next_fill_r + ONE_C;
              status_nxt      = ST_ADD_NEXT;
              state_nxt       = S_DONE;
            end
          end else begin
            if (sweep_fill_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              sweep_raddr = head_r;
              status_nxt  = ST_DISPATCH;
              state_nxt   = S_POP;
            end
          end
        end
      end

      // walk back from the tail, one entry per read/compare pair
      S_INS_RD: begin
        if (j_r == j_stop) begin
          mem_ctl.sweep_we = 1'b1;
          sweep_waddr      = phys(head_r, j_r);
          sweep_wdata      = {tag_r, sec_r};
          sweep_fill_nxt   = sweep_fill_r + ONE_C;
          ins_end          = 1'b1;
        end else begin
          sweep_raddr = phys(head_r, j_r - ONE_C);
          state_nxt   = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        // adds go ahead of equal sectors, move-in keeps arrival order
        if (mv_r ? (!a_lt_b && !a_eq_b) : !a_lt_b) begin
          mem_ctl.sweep_we = 1'b1;
          sweep_waddr      = phys(head_r, j_r);
          sweep_wdata      = sweep_rdata;
          j_nxt            = j_r - ONE_C;
          state_nxt        = S_INS_RD;
        end else begin
          mem_ctl.sweep_we = 1'b1;
          sweep_waddr      = phys(head_r, j_r);
          sweep_wdata      = {tag_r, sec_r};
          sweep_fill_nxt   = sweep_fill_r + ONE_C;
          ins_end          = 1'b1;
        end
      end

      S_POP: begin
        osec_nxt       = sweep_rdata[SECTOR_BITS-1:0];
        otag_nxt       = sweep_rdata[EW-1:SECTOR_BITS];
        sweep_fill_nxt = fill_dec;
        head_nxt       = phys(head_r, ONE_C);
        if (fill_dec == '0) begin
          if (next_fill_r == '0) begin
            pos_nxt   = '1;
            state_nxt = S_DONE;
          end else begin
            head_nxt   = '0;
            mv_nxt     = 1'b1;
            i_nxt      = '0;
            next_raddr = '0;
            state_nxt  = S_MV_LD;
          end
        end else begin
          state_nxt = S_HEAD_RD;
        end
      end

      S_MV_LD: begin
        sec_nxt   = next_rdata[SECTOR_BITS-1:0];
        tag_nxt   = next_rdata[EW-1:SECTOR_BITS];
        j_nxt     = sweep_fill_r;
        state_nxt = S_INS_RD;
      end

      S_HEAD_RD: begin
        sweep_raddr = head_r;
        state_nxt   = S_POS;
      end

      S_POS: begin
        pos_nxt   = sweep_rdata[SECTOR_BITS-1:0];
        state_nxt = S_DONE;
      end

      S_DONE: begin
        done = 1'b1;
        if (done_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ins_end) begin
      if (!mv_r) begin
        state_nxt = S_DONE;
      end else if (i_inc == next_fill_r) begin
        next_fill_nxt = '0;
        mv_nxt        = 1'b0;
        state_nxt     = S_HEAD_RD;
      end else begin
        i_nxt      = i_inc;
        next_raddr = i_inc[AW-1:0];
        state_nxt  = S_MV_LD;
      end
    end
  end

  assign sweep_ext       = XW'(sweep_fill_r);
  assign next_ext        = XW'(next_fill_r);
  assign res_status      = status_r;
  assign res_sector      = osec_r;
  assign res_tag         = otag_r;
  assign res_head        = pos_r;
  assign res_sweep_count = sweep_ext[COUNT_W-1:0];
  assign res_next_count  = next_ext[COUNT_W-1:0];

endmodule

>>> hw/rtl/clook_request_scheduler_unit.sv
// Top level of the C-LOOK request scheduler: stream ports, output register, core.
// Request handling: next-sweep add, reject, empty dispatch and an add into an empty
//   sweep list complete from idle; other sweep adds walk back from the tail, one
//   entry per read/compare pair; dispatch pops the head and, when the sweep empties,
//   moves each next-sweep request in by the same walk before reading the new head.
// Throughput: one request at a time through one read and one write port per list
//   memory; a finished result meeting a full output register holds the core.
// Reset (rst_n low, synchronous): lists empty, sweep position all ones, no result
//   pending; list memories are not cleared and need no clearing pass.
module clook_request_scheduler_unit import csched_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int SECTOR_BITS = SECTOR_BITS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_tvalid,
  output logic                                            in_tready,
  // request_sector, request_tag (lowest bit up), zero padded to bytes
  input  logic [((SECTOR_BITS+TAG_BITS+7)/8)*8-1:0]       in_tdata,
  // operation
  input  logic                                            in_tuser,
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  // out_sector, out_tag, sweep_head, sweep_count, next_count (lowest bit up)
  output logic [((2*SECTOR_BITS+TAG_BITS+2*COUNT_W+7)/8)*8-1:0] out_tdata,
  // status
  output logic [STATUS_W-1:0]                             out_tuser
);

  localparam int IN_DW  = ((SECTOR_BITS + TAG_BITS + 7) / 8) * 8;
  localparam int OUT_DW = ((2 * SECTOR_BITS + TAG_BITS + 2 * COUNT_W + 7) / 8) * 8;
  localparam int AW     = $clog2(QUEUE_DEPTH);
  localparam int EW     = SECTOR_BITS + TAG_BITS;

  logic                   start;
  logic                   seq_idle;
  logic                   seq_done;
  logic                   done_take;
  status_t                res_status;
  logic [SECTOR_BITS-1:0] res_sector;
  logic [TAG_BITS-1:0]    res_tag;
  logic [SECTOR_BITS-1:0] res_head;
  logic [COUNT_W-1:0]     res_sweep_count;
  logic [COUNT_W-1:0]     res_next_count;

  mem_ctl_t               mem_ctl;
  logic [AW-1:0]          sweep_waddr, sweep_raddr, next_waddr, next_raddr;
  logic [EW-1:0]          sweep_wdata, sweep_rdata, next_wdata, next_rdata;

  logic                   out_valid_r;
  logic [OUT_DW-1:0]      out_data_r;
  logic [STATUS_W-1:0]    out_user_r;

  // The core takes a request only from its idle state; a finished result
  // leaves through the output register, so the next request can come in while
  // the previous result is still waiting downstream.
  assign in_tready = seq_idle;
  assign start     = in_tvalid && in_tready;

  // Output register is free when empty or being drained this cycle.
  assign done_take = !out_valid_r || out_tready;

  csched_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SECTOR_BITS (SECTOR_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .start_op        (op_t'(in_tuser)),
    .start_sector    (in_tdata[SECTOR_BITS-1:0]),
    .start_tag       (in_tdata[EW-1:SECTOR_BITS]),
    .idle            (seq_idle),
    .done            (seq_done),
    .done_take       (done_take),
    .res_status      (res_status),
    .res_sector      (res_sector),
    .res_tag         (res_tag),
    .res_head        (res_head),
    .res_sweep_count (res_sweep_count),
    .res_next_count  (res_next_count),
    .mem_ctl         (mem_ctl),
    .sweep_waddr     (sweep_waddr),
    .sweep_raddr     (sweep_raddr),
    .sweep_wdata     (sweep_wdata),
    .sweep_rdata     (sweep_rdata),
    .next_waddr      (next_waddr),
    .next_raddr      (next_raddr),
    .next_wdata      (next_wdata),
    .next_rdata      (next_rdata)
  );

  // Sweep list is a circular buffer (head pointer in the sequencer);
  // next-sweep list is a plain append buffer in arrival order.
  csched_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_W     (EW)
  ) u_mem (
    .clk         (clk),
    .mem_ctl     (mem_ctl),
    .sweep_waddr (sweep_waddr),
    .sweep_raddr (sweep_raddr),
    .sweep_wdata (sweep_wdata),
    .sweep_rdata (sweep_rdata),
    .next_waddr  (next_waddr),
    .next_raddr  (next_raddr),
    .next_wdata  (next_wdata),
    .next_rdata  (next_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_done && done_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload: unused upper bits come out zero through the size cast.
  always_ff @(posedge clk) begin
    if (seq_done && done_take) begin
      out_data_r <= OUT_DW'({res_next_count, res_sweep_count, res_head, res_tag, res_sector});
      out_user_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // IN_DW documents the padded request width used in the port declaration.
  if (IN_DW < EW) begin : g_width_check
    $error("request data port narrower than its fields");
  end

endmodule

>>> hw/rtl/csched_checker.sv
// Port-level checker for the C-LOOK request scheduler, bound to the top level.
module csched_checker import csched_pkg::*; #(
  parameter int SECTOR_BITS = SECTOR_BITS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input logic                                                  clk,
  input logic                                                  rst_n,
  input logic                                                  in_tvalid,
  input logic                                                  in_tready,
  input logic                                                  out_tvalid,
  input logic                                                  out_tready,
  input logic [((2*SECTOR_BITS+TAG_BITS+2*COUNT_W+7)/8)*8-1:0] out_tdata,
  input logic [STATUS_W-1:0]                                   out_tuser
);

  localparam int HEAD_LO = SECTOR_BITS + TAG_BITS;
  localparam int SWC_LO  = 2 * SECTOR_BITS + TAG_BITS;
  localparam int NXC_LO  = SWC_LO + COUNT_W;

  // one request at a time: after taking one the core is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while core busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // nothing pending means both lists empty and the idle sweep position
  a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |->
      out_tdata[SWC_LO+COUNT_W-1:SWC_LO] == '0 &&
      out_tdata[NXC_LO+COUNT_W-1:NXC_LO] == '0 &&
      out_tdata[HEAD_LO+SECTOR_BITS-1:HEAD_LO] == '1)
    else $error("empty dispatch with requests pending");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DISPATCH |-> out_tdata[HEAD_LO-1:0] == '0)
    else $error("non-dispatch result carries a request");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind clook_request_scheduler_unit csched_checker #(
  .SECTOR_BITS (SECTOR_BITS),
  .TAG_BITS    (TAG_BITS)
) u_csched_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> tb/clook_request_scheduler_unit_tb.sv
// Self-checking testbench for the C-LOOK request scheduler: random stream traffic, scoreboard.
module clook_request_scheduler_unit_tb import csched_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEC_W = SECTOR_BITS_DEF;
  localparam int TAG_W = TAG_BITS_DEF;
  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int IN_W  = ((SEC_W + TAG_W + 7) / 8) * 8;
  localparam int OUT_W = ((2 * SEC_W + TAG_W + 2 * COUNT_W + 7) / 8) * 8;
  localparam logic [SEC_W-1:0] SEC_MAX = '1;
  // worst case per request is a full handover; a whole run stays far below this limit
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_REQUESTS = 800;

  // one entry of either request list
  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic [TAG_W-1:0] tag;
  } slot_t;

  // everything one request reports back
  typedef struct packed {
    status_t              status;
    logic [SEC_W-1:0]     sector;
    logic [TAG_W-1:0]     tag;
    logic [SEC_W-1:0]     head;
    logic [COUNT_W-1:0]   sweep_cnt;
    logic [COUNT_W-1:0]   next_cnt;
  } sched_reply_t;

  // Tracks both request lists and the sweep position, and holds the replies owed
  // by the block in request order.
  class sched_scoreboard;
    slot_t            sweep_list[$];
    slot_t            next_list[$];
    logic [SEC_W-1:0] position;
    sched_reply_t     due_replies[$];
    int               errors;

    function new();
      position = SEC_MAX;
      errors   = 0;
    endfunction

    // accepted request: update the list model and queue the reply it owes
    function void note_request(op_t op, logic [SEC_W-1:0] sector, logic [TAG_W-1:0] tag);
      sched_reply_t r;
      slot_t        e;
      slot_t        m;
      int           pos;
      int           j;
      r.status = ST_EMPTY;
      r.sector = '0;
      r.tag    = '0;
      e.sector = sector;
      e.tag    = tag;
      if (op == OP_ADD) begin
        if (sweep_list.size() == 0 || sector >= position) begin
          if (sweep_list.size() >= DEPTH) begin
            r.status = ST_REJECT;
          end else begin
            // head stays put; go before the first later entry with sector >= ours
            pos = (sweep_list.size() == 0) ? 0 : 1;
            while (pos < sweep_list.size() && sector > sweep_list[pos].sector) pos++;
            sweep_list.insert(pos, e);
            r.status = ST_ADD_SWEEP;
          end
        end else if (next_list.size() >= DEPTH) begin
          r.status = ST_REJECT;
        end else begin
          next_list.push_back(e);
          r.status = ST_ADD_NEXT;
        end
      end else if (sweep_list.size() != 0) begin
        m = sweep_list.pop_front();
        r.status = ST_DISPATCH;
        r.sector = m.sector;
        r.tag    = m.tag;
        if (sweep_list.size() == 0) begin
          // handover: stable insertion sort, equal sectors keep arrival order
          foreach (next_list[i]) begin
            j = sweep_list.size();
            while (j > 0 && sweep_list[j-1].sector > next_list[i].sector) j--;
            sweep_list.insert(j, next_list[i]);
          end
          next_list.delete();
        end
      end
      position    = (sweep_list.size() == 0) ? SEC_MAX : sweep_list[0].sector;
      r.head      = position;
      r.sweep_cnt = COUNT_W'(sweep_list.size());
      r.next_cnt  = COUNT_W'(next_list.size());
      due_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // accepted result: compare against the oldest owed reply
    function void check_result(logic [STATUS_W-1:0] st, logic [OUT_W-1:0] data);
      sched_reply_t w;
      if (due_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0h data %0h",
                 $time, st, data);
        return;
      end
      w = due_replies.pop_front();
      compare_field("status", 64'(w.status), 64'(st));
      compare_field("out_sector", 64'(w.sector), 64'(data[0 +: SEC_W]));
      compare_field("out_tag", 64'(w.tag), 64'(data[SEC_W +: TAG_W]));
      compare_field("sweep_head", 64'(w.head), 64'(data[SEC_W+TAG_W +: SEC_W]));
      compare_field("sweep_count", 64'(w.sweep_cnt), 64'(data[2*SEC_W+TAG_W +: COUNT_W]));
      compare_field("next_count", 64'(w.next_cnt),
                    64'(data[2*SEC_W+TAG_W+COUNT_W +: COUNT_W]));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;   // request_sector, request_tag (lowest bit up)
  logic in_tuser;              // operation
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata; // out_sector, out_tag, sweep_head, sweep_count, next_count
  logic [STATUS_W-1:0] out_tuser; // status

  sched_scoreboard sb;
  int  requests_sent = 0;
  int  cycles = 0;
  bit  calm = 1'b0;  // set for stretches with no idling on either side

  clook_request_scheduler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [SEC_W-1:0] pick_sector();
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SEC_MAX;
      2, 3, 4: return SEC_W'($urandom_range(0, 63));
      5:       return SEC_MAX - SEC_W'($urandom_range(0, 63));
      default: return r64[SEC_W-1:0];
    endcase
  endfunction

  // Present one request, hold it until taken, then note it. tvalid stays high into the
  // next request when the drawn gap is zero, so it never drops and rises in one step.
  task automatic send_request(op_t op, logic [SEC_W-1:0] sector, logic [TAG_W-1:0] tag);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_W'({tag, sector});
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, sector, tag);
    requests_sent++;
    gap = draw_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // dispatch with junk in the add fields, which the block must ignore
  task automatic send_dispatch();
    send_request(OP_DISPATCH, SEC_W'({$urandom, $urandom}), TAG_W'($urandom_range(0, 255)));
  endtask

  task automatic mixed_burst(int n);
    int add_pct;
    case ($urandom_range(0, 3))
      0:       add_pct = 25;
      1:       add_pct = 50;
      2:       add_pct = 80;
      default: add_pct = 95;
    endcase
    repeat (n) begin
      if ($urandom_range(0, 99) < add_pct)
        send_request(OP_ADD, pick_sector(), TAG_W'($urandom_range(0, 255)));
      else send_dispatch();
    end
  endtask

  // adds at or past the sweep position until the sweep list overflows
  task automatic fill_sweep_burst();
    logic [SEC_W-1:0] lo;
    logic [SEC_W-1:0] s;
    lo = (sb.sweep_list.size() == 0) ? pick_sector() : sb.position;
    repeat (DEPTH + 2) begin
      s = lo + SEC_W'($urandom_range(0, 4095));
      if (s < lo) s = SEC_MAX;
      send_request(OP_ADD, s, TAG_W'($urandom_range(0, 255)));
    end
  endtask

  // adds below the sweep position until the next-sweep list overflows
  task automatic fill_next_burst();
    logic [63:0] r64;
    if (sb.sweep_list.size() == 0)
      send_request(OP_ADD, SEC_MAX - SEC_W'($urandom_range(0, 1 << 20)),
                   TAG_W'($urandom_range(0, 255)));
    if (sb.position == '0) begin
      send_dispatch();
      return;
    end
    repeat (DEPTH + 2) begin
      r64 = {$urandom, $urandom};
      // narrow range now and then so sectors tie
      if ($urandom_range(0, 1)) r64 = r64 % 8;
      send_request(OP_ADD, SEC_W'(r64 % 64'(sb.position)), TAG_W'($urandom_range(0, 255)));
    end
  endtask

  // pop everything, handover included, and run into the empty case
  task automatic drain_burst();
    repeat (sb.sweep_list.size() + sb.next_list.size() + $urandom_range(1, 2)) send_dispatch();
  endtask

  // Result side: random stalls between results, tready held high when the stall is zero.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tuser, out_tdata);
    end
  end

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_ADD;
    in_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty dispatch, ties in both lists, sector and tag extremes, handover.
    send_request(OP_DISPATCH, SEC_MAX, 8'hff);
    send_request(OP_ADD, 48'd100, 8'd1);
    send_request(OP_ADD, 48'd50, 8'd2);     // below position: next sweep
    send_request(OP_ADD, 48'd100, 8'd3);    // ties the head, head not displaced
    send_request(OP_ADD, 48'd100, 8'd4);    // lands ahead of tag 3
    send_request(OP_ADD, SEC_MAX, 8'hff);
    send_request(OP_ADD, 48'd0, 8'd0);
    send_request(OP_ADD, 48'd50, 8'd5);     // tie in next list, arrival order kept
    send_request(OP_ADD, 48'd200, 8'd6);
    repeat (5) send_dispatch();             // last one empties sweep and swaps lists in
    repeat (3) send_dispatch();
    send_dispatch();                        // nothing pending
    send_request(OP_ADD, 48'd0, 8'hff);
    send_request(OP_ADD, SEC_MAX, 8'd0);
    send_request(OP_ADD, 48'd0, 8'h80);
    repeat (4) send_dispatch();

    // Random: bursts of mixed traffic plus list overflows and full drains.
    requests_sent = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: mixed_burst($urandom_range(10, 40));
        5, 6:          fill_sweep_burst();
        7:             fill_next_burst();
        default:       drain_burst();
      endcase
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.due_replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/csched_pkg.sv
hw/rtl/csched_mem.sv
hw/rtl/csched_seq.sv
hw/rtl/clook_request_scheduler_unit.sv
hw/rtl/csched_checker.sv
tb/clook_request_scheduler_unit_tb.sv
